// ===== rtl/core/kccp_pkg.sv =====
package kccp_pkg;

    localparam int RGB_W  = 24;
    localparam int DIST_W = 18;

    localparam logic CFG_NUM_CENTERS = 1'b0;
    localparam logic CFG_PASS_LIMIT  = 1'b1;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_CHK,
        ST_SEED_WAIT,
        ST_SEARCH,
        ST_ACCUM,
        ST_PX_LOAD,
        ST_PX_WAIT,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_MEAN_ACC,
        ST_DECIDE,
        ST_REP_LOAD,
        ST_REP_WAIT,
        ST_CLEAR
    } kccp_state_t;

    typedef struct packed {
        logic in_take;
        logic idx_clr;
        logic idx_inc;
        logic chan_clr;
        logic chan_inc;
        logic search_step;
        logic accum;
        logic px_load;
        logic div_start;
        logic div_seed;
        logic mean_store;
        logic shift_clr;
        logic shift_add;
        logic decide;
        logic rep_load;
        logic acc_clr;
        logic pass_clr;
        logic seed_zero;
        logic seed_write;
    } kccp_cmd_t;

    typedef struct packed {
        logic in_accept;
        logic is_pixel;
        logic fin;
        logic idx_last_n;
        logic idx_lt_n;
        logic seed_end;
        logic chan_last;
        logic div_done;
        logic out_done;
    } kccp_stat_t;

    // Squared RGB distance between two packed colors.
    function automatic logic [DIST_W-1:0] sq_dist(input logic [RGB_W-1:0] a,
                                                  input logic [RGB_W-1:0] b);
        logic signed [DIST_W-1:0] dr;
        logic signed [DIST_W-1:0] dg;
        logic signed [DIST_W-1:0] db;
        logic [DIST_W-1:0]        acc;
        dr = DIST_W'($signed({1'b0, a[23:16]}) - $signed({1'b0, b[23:16]}));
        dg = DIST_W'($signed({1'b0, a[15:8]}) - $signed({1'b0, b[15:8]}));
        db = DIST_W'($signed({1'b0, a[7:0]}) - $signed({1'b0, b[7:0]}));
        acc = DIST_W'($unsigned(dr * dr)) + DIST_W'($unsigned(dg * dg))
            + DIST_W'($unsigned(db * db));
        return acc;
    endfunction

endpackage

// ===== rtl/core/kccp_div.sv =====
module kccp_div #(
    parameter int DW = 32,
    parameter int VW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNW = $clog2(DW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [VW-1:0]  dvs_reg, dvs_next;
    logic [VW:0]    trial;
    logic           ge;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNW'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/kccp_ctrl.sv =====
module kccp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  kccp_pkg::kccp_stat_t stat,
    output kccp_pkg::kccp_cmd_t  cmd
);
    import kccp_pkg::*;

    kccp_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_accept)
                begin
                    state_next = stat.is_pixel ? ST_SEARCH : ST_SEED_CHK;
                end
            end
            ST_SEED_CHK:
            begin
                if (stat.idx_lt_n)
                begin
                    state_next = ST_SEED_WAIT;
                end
                else if (stat.seed_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEED_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.seed_end ? ST_IDLE : ST_SEED_CHK;
                end
            end
            ST_SEARCH:
            begin
                if (stat.idx_last_n)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:      state_next = ST_PX_LOAD;
            ST_PX_LOAD:    state_next = ST_PX_WAIT;
            ST_PX_WAIT:
            begin
                if (stat.out_done)
                begin
                    state_next = stat.fin ? ST_MEAN_START : ST_IDLE;
                end
            end
            ST_MEAN_START: state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.chan_last ? ST_MEAN_ACC : ST_MEAN_START;
                end
            end
            ST_MEAN_ACC:
            begin
                state_next = stat.idx_last_n ? ST_DECIDE : ST_MEAN_START;
            end
            ST_DECIDE:     state_next = ST_REP_LOAD;
            ST_REP_LOAD:   state_next = ST_REP_WAIT;
            ST_REP_WAIT:
            begin
                if (stat.out_done)
                begin
                    state_next = stat.idx_last_n ? ST_CLEAR : ST_REP_LOAD;
                end
            end
            ST_CLEAR:      state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_take = 1'b1;
                cmd.idx_clr = 1'b1;
                if (stat.in_accept && !stat.is_pixel)
                begin
                    cmd.acc_clr  = 1'b1;
                    cmd.pass_clr = 1'b1;
                end
            end
            ST_SEED_CHK:
            begin
                if (stat.idx_lt_n)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_seed  = 1'b1;
                end
                else
                begin
                    cmd.seed_zero = 1'b1;
                    cmd.idx_inc   = !stat.seed_end;
                end
            end
            ST_SEED_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.seed_write = 1'b1;
                    cmd.idx_inc    = !stat.seed_end;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                cmd.idx_inc     = !stat.idx_last_n;
            end
            ST_ACCUM:   cmd.accum = 1'b1;
            ST_PX_LOAD: cmd.px_load = 1'b1;
            ST_PX_WAIT:
            begin
                cmd.idx_clr   = 1'b1;
                cmd.chan_clr  = 1'b1;
                cmd.shift_clr = 1'b1;
            end
            ST_MEAN_START: cmd.div_start = 1'b1;
            ST_MEAN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_store = 1'b1;
                    cmd.chan_inc   = 1'b1;
                end
            end
            ST_MEAN_ACC:
            begin
                cmd.shift_add = 1'b1;
                cmd.chan_clr  = 1'b1;
                cmd.idx_inc   = !stat.idx_last_n;
                cmd.idx_clr   = stat.idx_last_n;
            end
            ST_DECIDE:   cmd.decide = 1'b1;
            ST_REP_LOAD: cmd.rep_load = 1'b1;
            ST_REP_WAIT:
            begin
                if (stat.out_done)
                begin
                    cmd.idx_inc = !stat.idx_last_n;
                end
            end
            ST_CLEAR:    cmd.acc_clr = 1'b1;
            default:     cmd = '0;
        endcase
    end

    // After reset the centers are seeded before the first item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEED_CHK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/kccp_dp.sv =====
module kccp_dp #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_PIXELS  = 1048576
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kccp_pkg::kccp_cmd_t  cmd,
    output kccp_pkg::kccp_stat_t stat,
    input  logic                 in_valid,
    input  logic                 req_type,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic                 last_pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 kind,
    output logic [3:0]           cluster,
    output logic [7:0]           red_out,
    output logic [7:0]           green_out,
    output logic [7:0]           blue_out,
    output logic [21:0]          shift_total,
    output logic                 converged,
    output logic                 frame_overflow,
    output logic                 last,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);
    import kccp_pkg::*;

    localparam int IW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int NW  = $clog2(MAX_CENTERS + 1);
    localparam int PW  = $clog2(MAX_PIXELS + 1);
    localparam int SW  = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1);
    localparam int SHW = $clog2(MAX_CENTERS * 195075 + 1);
    localparam int DW  = (SW > RGB_W + NW) ? SW : RGB_W + NW;
    localparam int VW  = (PW > NW + 1) ? PW : NW + 1;

    logic [4:0]        num_centers_reg;
    logic [7:0]        pass_limit_reg;
    logic [NW-1:0]     n_eff;

    logic [RGB_W-1:0]  px_reg;
    logic              fin_reg;
    logic [IW-1:0]     idx_reg;
    logic [1:0]        chan_reg;
    logic [IW-1:0]     best_reg;
    logic [DIST_W-1:0] bestd_reg;
    logic [RGB_W-1:0]  best_rgb_reg;
    logic [RGB_W-1:0]  mean_work_reg;
    logic [SHW-1:0]    shift_reg;
    logic              conv_reg;
    logic [7:0]        pass_count_reg;
    logic [PW-1:0]     pixel_total_reg;
    logic              overflow_reg;

    logic [RGB_W-1:0]  center_reg [MAX_CENTERS];
    logic [RGB_W-1:0]  means_reg  [MAX_CENTERS];
    logic [SW-1:0]     rsum_reg   [MAX_CENTERS];
    logic [SW-1:0]     gsum_reg   [MAX_CENTERS];
    logic [SW-1:0]     bsum_reg   [MAX_CENTERS];
    logic [PW-1:0]     cnt_reg    [MAX_CENTERS];

    logic              out_valid_reg;
    logic              kind_reg;
    logic [3:0]        cluster_reg;
    logic [RGB_W-1:0]  rgb_out_reg;
    logic [21:0]       shift_out_reg;
    logic              conv_out_reg;
    logic              ovf_out_reg;
    logic              last_reg;

    logic [DIST_W-1:0] px_dist;
    logic [RGB_W-1:0]  cen_rd;
    logic [SW-1:0]     sum_sel;
    logic [DW-1:0]     div_dividend;
    logic [VW-1:0]     div_divisor;
    logic              div_done;
    logic [DW-1:0]     div_q;
    logic [7:0]        mean_byte;
    logic [7:0]        pass_next;
    logic              conv_now;
    logic [NW-1:0]     idx_ext;

    always_comb
    begin
        if (num_centers_reg == 5'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(num_centers_reg) > 32'(MAX_CENTERS))
        begin
            n_eff = NW'(MAX_CENTERS);
        end
        else
        begin
            n_eff = NW'(num_centers_reg);
        end
    end

    assign idx_ext = NW'(idx_reg);
    assign cen_rd  = center_reg[idx_reg];
    assign px_dist = sq_dist(px_reg, cen_rd);

    always_comb
    begin
        case (chan_reg)
            2'd0:    sum_sel = rsum_reg[idx_reg];
            2'd1:    sum_sel = gsum_reg[idx_reg];
            default: sum_sel = bsum_reg[idx_reg];
        endcase
    end

    assign div_dividend = cmd.div_seed ? DW'({idx_ext + NW'(1), 24'h000000})
                                       : DW'(sum_sel);
    assign div_divisor  = cmd.div_seed ? VW'(n_eff) + VW'(1) : VW'(cnt_reg[idx_reg]);

    kccp_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // An empty cluster averages to black.
    assign mean_byte = (cnt_reg[idx_reg] == '0) ? 8'd0 : div_q[7:0];
    assign pass_next = (pass_count_reg == 8'd255) ? 8'd255 : pass_count_reg + 8'd1;
    assign conv_now  = (32'(shift_reg) <= 32'(n_eff)) || (pass_next > pass_limit_reg);

    always_comb
    begin
        stat.in_accept  = in_valid && cmd.in_take;
        stat.is_pixel   = (req_type == REQ_PIXEL);
        stat.fin        = fin_reg;
        stat.idx_last_n = (idx_ext + NW'(1)) == n_eff;
        stat.idx_lt_n   = idx_ext < n_eff;
        stat.seed_end   = idx_reg == IW'(MAX_CENTERS - 1);
        stat.chan_last  = chan_reg == 2'd2;
        stat.div_done   = div_done;
        stat.out_done   = out_valid_reg && !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_centers_reg <= 5'd8;
            pass_limit_reg  <= 8'd100;
            idx_reg         <= '0;
            chan_reg        <= '0;
            pass_count_reg  <= '0;
            pixel_total_reg <= '0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_CENTERS; i++)
            begin
                rsum_reg[i] <= '0;
                gsum_reg[i] <= '0;
                bsum_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_NUM_CENTERS)
                begin
                    num_centers_reg <= cfg_data[4:0];
                end
                else
                begin
                    pass_limit_reg <= cfg_data;
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.chan_clr)
            begin
                chan_reg <= '0;
            end
            else if (cmd.chan_inc)
            begin
                chan_reg <= chan_reg + 2'd1;
            end
            if (cmd.pass_clr)
            begin
                pass_count_reg <= '0;
            end
            else if (cmd.decide)
            begin
                pass_count_reg <= pass_next;
            end
            if (cmd.acc_clr)
            begin
                pixel_total_reg <= '0;
                overflow_reg    <= 1'b0;
                for (int i = 0; i < MAX_CENTERS; i++)
                begin
                    rsum_reg[i] <= '0;
                    gsum_reg[i] <= '0;
                    bsum_reg[i] <= '0;
                    cnt_reg[i]  <= '0;
                end
            end
            else if (cmd.accum)
            begin
                if (pixel_total_reg == PW'(MAX_PIXELS))
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    rsum_reg[best_reg] <= rsum_reg[best_reg] + SW'(px_reg[23:16]);
                    gsum_reg[best_reg] <= gsum_reg[best_reg] + SW'(px_reg[15:8]);
                    bsum_reg[best_reg] <= bsum_reg[best_reg] + SW'(px_reg[7:0]);
                    cnt_reg[best_reg]  <= cnt_reg[best_reg] + PW'(1);
                    pixel_total_reg    <= pixel_total_reg + PW'(1);
                end
            end
            if (cmd.px_load || cmd.rep_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.in_accept)
        begin
            px_reg  <= {red, green, blue};
            fin_reg <= last_pixel;
        end
        if (cmd.search_step && (idx_reg == '0 || px_dist < bestd_reg))
        begin
            best_reg     <= idx_reg;
            bestd_reg    <= px_dist;
            best_rgb_reg <= cen_rd;
        end
        if (cmd.seed_zero)
        begin
            center_reg[idx_reg] <= '0;
        end
        else if (cmd.seed_write)
        begin
            center_reg[idx_reg] <= div_q[RGB_W-1:0];
        end
        else if (cmd.rep_load && !conv_reg)
        begin
            center_reg[idx_reg] <= means_reg[idx_reg];
        end
        if (cmd.mean_store)
        begin
            mean_work_reg <= {mean_work_reg[15:0], mean_byte};
        end
        if (cmd.shift_clr)
        begin
            shift_reg <= '0;
        end
        else if (cmd.shift_add)
        begin
            shift_reg           <= shift_reg + SHW'(sq_dist(mean_work_reg, cen_rd));
            means_reg[idx_reg]  <= mean_work_reg;
        end
        if (cmd.decide)
        begin
            conv_reg <= conv_now;
        end
        if (cmd.px_load)
        begin
            kind_reg      <= KIND_ASSIGN;
            cluster_reg   <= 4'(best_reg);
            rgb_out_reg   <= best_rgb_reg;
            shift_out_reg <= '0;
            conv_out_reg  <= 1'b0;
            ovf_out_reg   <= overflow_reg;
            last_reg      <= !fin_reg;
        end
        else if (cmd.rep_load)
        begin
            kind_reg      <= KIND_REPORT;
            cluster_reg   <= 4'(idx_reg);
            rgb_out_reg   <= conv_reg ? cen_rd : means_reg[idx_reg];
            shift_out_reg <= 22'(shift_reg);
            conv_out_reg  <= conv_reg;
            ovf_out_reg   <= overflow_reg;
            last_reg      <= stat.idx_last_n;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign cluster        = cluster_reg;
    assign red_out        = rgb_out_reg[23:16];
    assign green_out      = rgb_out_reg[15:8];
    assign blue_out       = rgb_out_reg[7:0];
    assign shift_total    = shift_out_reg;
    assign converged      = conv_out_reg;
    assign frame_overflow = ovf_out_reg;
    assign last           = last_reg;

endmodule

// ===== rtl/core/kmeans_color_cluster_pass.sv =====
// One k-means pass per frame of RGB pixels, one item in flight at a time. A pixel's
// nearest-center search visits one center per cycle over the N centers in use,
// and the pixel then waits for its result beat to be taken. The last pixel of a
// frame then computes every cluster mean on a shared restoring divider, three
// divisions per center, one per color channel, and emits one report beat per
// center. A restart, and the period right after reset during which no item is
// accepted, seeds the centers with one divider run per center in use and zeroes
// each remaining table entry.
// Configuration is always ready and should be written only while the block idles.
module kmeans_color_cluster_pass #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_PIXELS  = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [3:0]  cluster,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [21:0] shift_total,
    output logic        converged,
    output logic        frame_overflow,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import kccp_pkg::*;

    kccp_cmd_t  cmd;
    kccp_stat_t stat;

    assign in_stall  = !cmd.in_take;
    assign cfg_ready = 1'b1;

    kccp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    kccp_dp #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_PIXELS  (MAX_PIXELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_valid       (in_valid),
        .req_type       (req_type),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .last_pixel     (last_pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .cluster        (cluster),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .shift_total    (shift_total),
        .converged      (converged),
        .frame_overflow (frame_overflow),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

// ===== sim/tb_kmeans_color_cluster_pass.sv =====
`timescale 1ns / 100ps

module tb_kmeans_color_cluster_pass;
    import kccp_pkg::*;

    localparam int NCTR       = 16;
    localparam int PIX_CAP    = 1048576;
    localparam int QUIET_WAIT = 1200;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct packed {
        logic        kind;
        logic [3:0]  cluster;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [21:0] shift;
        logic        conv;
        logic        ovf;
        logic        last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [3:0]  cluster;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [21:0] shift_total;
    logic        converged;
    logic        frame_overflow;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    // Shadow copy of the block's state.
    logic [23:0]     ctr_tab[NCTR];
    longint unsigned rsum[NCTR];
    longint unsigned gsum[NCTR];
    longint unsigned bsum[NCTR];
    longint unsigned members[NCTR];
    longint unsigned px_total;
    logic            ovf_seen;
    int unsigned     passes;
    logic [4:0]      ctr_cfg;
    logic [7:0]      limit_cfg;

    beat_t       pending_beats[$];
    int          errors;
    int          sender_idle_pct;
    int          recv_idle_pct;
    longint      cycles;
    logic [23:0] palette[4];

    kmeans_color_cluster_pass u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .red(red), .green(green), .blue(blue),
        .last_pixel(last_pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .cluster(cluster), .red_out(red_out), .green_out(green_out),
        .blue_out(blue_out), .shift_total(shift_total), .converged(converged),
        .frame_overflow(frame_overflow), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned centers_in_use();
        int unsigned n;
        n = ctr_cfg;
        if (n < 1) n = 1;
        if (n > NCTR) n = NCTR;
        return n;
    endfunction

    function automatic int unsigned color_dist(logic [23:0] a, logic [23:0] b);
        int dr;
        int dg;
        int db;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    task automatic clear_sums();
        for (int i = 0; i < NCTR; i++)
        begin
            rsum[i] = 0;
            gsum[i] = 0;
            bsum[i] = 0;
            members[i] = 0;
        end
        px_total = 0;
        ovf_seen = 1'b0;
    endtask

    task automatic reseed_centers();
        int unsigned n;
        n = centers_in_use();
        for (int i = 0; i < NCTR; i++)
            ctr_tab[i] = (i < n) ? 24'((64'd16777216 * (i + 1)) / (n + 1)) : 24'd0;
        passes = 0;
        clear_sums();
    endtask

    task automatic push_beat(logic k, int unsigned idx, logic [23:0] rgb,
                             int unsigned sh, logic cv, logic lst);
        beat_t e;
        e.kind = k;
        e.cluster = 4'(idx);
        e.r = rgb[23:16];
        e.g = rgb[15:8];
        e.b = rgb[7:0];
        e.shift = 22'(sh);
        e.conv = cv;
        e.ovf = ovf_seen;
        e.last = lst;
        pending_beats.push_back(e);
    endtask

    // Works out the beats caused by one accepted pixel.
    task automatic predict_pixel(logic [23:0] px, logic fin);
        int unsigned n;
        int unsigned best;
        int unsigned bestd;
        int unsigned d;
        int unsigned shift;
        logic        conv;
        logic [23:0] means[NCTR];
        n = centers_in_use();
        best = 0;
        bestd = color_dist(px, ctr_tab[0]);
        for (int i = 1; i < n; i++)
        begin
            d = color_dist(px, ctr_tab[i]);
            if (d < bestd)
            begin
                bestd = d;
                best = i;
            end
        end
        if (px_total >= PIX_CAP)
            ovf_seen = 1'b1;
        else
        begin
            rsum[best] += px[23:16];
            gsum[best] += px[15:8];
            bsum[best] += px[7:0];
            members[best] += 1;
            px_total += 1;
        end
        push_beat(KIND_ASSIGN, best, ctr_tab[best], 0, 1'b0, !fin);
        if (!fin)
            return;
        shift = 0;
        for (int i = 0; i < n; i++)
        begin
            means[i] = 24'd0;
            if (members[i] > 0)
                means[i] = {8'(rsum[i] / members[i]), 8'(gsum[i] / members[i]),
                            8'(bsum[i] / members[i])};
            shift += color_dist(means[i], ctr_tab[i]);
        end
        if (passes < 255) passes++;
        conv = (shift <= n) || (passes > limit_cfg);
        if (!conv)
            for (int i = 0; i < n; i++) ctr_tab[i] = means[i];
        for (int i = 0; i < n; i++)
            push_beat(KIND_REPORT, i, ctr_tab[i], shift, conv, i + 1 == n);
        clear_sums();
    endtask

    task automatic send_item(logic rt, logic [23:0] px, logic lp);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        red <= px[23:16];
        green <= px[15:8];
        blue <= px[7:0];
        last_pixel <= lp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (rt == REQ_RESTART)
            reseed_centers();
        else
            predict_pixel(px, lp);
    endtask

    // Lets the block drain, including work that yields no beat.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_NUM_CENTERS)
            ctr_cfg = val[4:0];
        else
            limit_cfg = val;
    endtask

    task automatic reconfigure(logic [7:0] n, logic [7:0] lim);
        wait_quiet();
        write_reg(CFG_NUM_CENTERS, n);
        write_reg(CFG_PASS_LIMIT, lim);
    endtask

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL kmeans_color_cluster_pass");
            $finish;
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, cluster, red_out, green_out, blue_out, shift_total,
                   converged, frame_overflow, last};
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: kind %0d cluster %0d", kind, cluster);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp kind %0d cl %0d rgb %h%h%h sh %0d cv %0d ",
                                  "ov %0d last %0d / got kind %0d cl %0d rgb %h%h%h ",
                                  "sh %0d cv %0d ov %0d last %0d"},
                                 want.kind, want.cluster, want.r, want.g, want.b,
                                 want.shift, want.conv, want.ovf, want.last,
                                 got.kind, got.cluster, got.r, got.g, got.b,
                                 got.shift, got.conv, got.ovf, got.last);
                end
            end
        end
    end

    task automatic test_directed();
        logic [23:0] corners[8];
        corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                    24'h808080, 24'h555555, 24'h7F7F7F};
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        // Reset setting: eight centers, three pixels share one cluster and two share another.
        foreach (corners[i]) send_item(REQ_PIXEL, corners[i], i == 7);
        // Single center, then frame end with lots of empty clusters.
        reconfigure(8'd0, 8'd1);
        send_item(REQ_RESTART, 24'h0, 1'b0);
        send_item(REQ_PIXEL, 24'h123456, 1'b1);
        reconfigure(8'd16, 8'd255);
        send_item(REQ_RESTART, 24'h0, 1'b0);
        send_item(REQ_PIXEL, 24'hFFFFFF, 1'b0);
        send_item(REQ_PIXEL, 24'h000000, 1'b1);
        // Count above the table size clamps; change it in the middle of a frame.
        reconfigure(8'd31, 8'd1);
        send_item(REQ_PIXEL, 24'hA0B0C0, 1'b0);
        reconfigure(8'd3, 8'd1);
        send_item(REQ_PIXEL, 24'h0F0F0F, 1'b1);
        // The same one-pixel frame repeated, with the pass count already past the limit.
        repeat (3) send_item(REQ_PIXEL, 24'h404040, 1'b1);
    endtask

    task automatic test_random(int s_pct, int r_pct, int items);
        int          done;
        int          len;
        logic [23:0] px;
        int          k;
        sender_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < 4; i++) palette[i] = 24'($urandom);
        done = 0;
        while (done < items)
        begin
            if ($urandom_range(99) < 5)
            begin
                send_item(REQ_RESTART, 24'($urandom), 1'($urandom_range(1)));
                done++;
            end
            len = $urandom_range(1, 12);
            for (int p = 0; p < len; p++)
            begin
                px = 24'($urandom);
                if ($urandom_range(99) < 75)
                begin
                    k = $urandom_range(3);
                    px = palette[k] ^ 24'($urandom_range(0, 7) * 24'h010101);
                end
                send_item(REQ_PIXEL, px, p == len - 1);
                done++;
            end
            if ($urandom_range(99) < 12)
            begin
                if ($urandom_range(99) < 70)
                    reconfigure(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
                else
                    reconfigure(8'($urandom), 8'($urandom_range(1, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_PIXEL;
        red <= 8'd0;
        green <= 8'd0;
        blue <= 8'd0;
        last_pixel <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NUM_CENTERS;
        cfg_data <= 8'd0;
        errors = 0;
        cycles = 0;
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        ctr_cfg = 5'd8;
        limit_cfg = 8'd100;
        reseed_centers();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(15, 50, 150);
        test_random(50, 15, 150);
        test_random(0, 0, 150);
        wait_quiet();
        if (errors == 0)
            $display("PASS kmeans_color_cluster_pass");
        else
            $display("FAIL kmeans_color_cluster_pass");
        $finish;
    end

endmodule
